// File: rtl/core/esc_pkg.sv
package esc_pkg;

  // Divider width and datapath constants of the compensation formulas.
  localparam int DIV_W = 32;
  localparam int IDX_W = 2;
  localparam int CFG_W = 64;
  localparam int TCAL_W = 40;

  localparam logic signed [31:0] PRES_OFFSET = 32'sd64000;
  localparam logic [31:0]        PRES_BASE   = 32'd1048576;
  localparam logic [31:0]        PRES_SCALE  = 32'd3125;
  localparam logic signed [31:0] PRES_ONE    = 32'sd32768;
  localparam logic signed [31:0] TEMP_ROUND  = 32'sd128;
  localparam logic signed [31:0] HUM_ONE     = 32'sd16384;
  localparam logic signed [31:0] HUM_SCALE   = 32'sd1000;
  localparam logic signed [31:0] HUM_MAX     = 32'sd100000;
  localparam logic [31:0]        DIV100_MAGIC  = 32'h51EB_851F;
  localparam logic [17:0]        DIV1000_MAGIC = 18'd134218;

  typedef enum logic [IDX_W-1:0] {
    REG_TEMP_CALIB   = 2'd0,
    REG_PRES_CALIB_A = 2'd1,
    REG_PRES_CALIB_B = 2'd2,
    REG_HUM_CALIB    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [TCAL_W-1:0] temp;
    logic [CFG_W-1:0]  pres_a;
    logic [CFG_W-1:0]  pres_b;
    logic [CFG_W-1:0]  hum;
  } calib_t;

  typedef struct packed {
    logic [7:0]  temperature_c;
    logic [10:0] pressure_hpa;
    logic [6:0]  humidity_pct;
    logic        pressure_fault;
  } result_t;

  // Values that ride alongside the pressure divider.
  typedef struct packed {
    logic [7:0]         deg;
    logic               fault;
    logic               big;
    logic signed [31:0] x1;
    logic signed [31:0] x2m;
    logic signed [31:0] x4;
  } side_t;

  function automatic logic signed [31:0] sx8(input logic [7:0] v);
    return $signed({{24{v[7]}}, v});
  endfunction

  function automatic logic signed [31:0] sx16(input logic [15:0] v);
    return $signed({{16{v[15]}}, v});
  endfunction

  // Unsigned divide by 100 through a reciprocal multiply, exact for 32-bit values.
  function automatic logic [31:0] udiv100(input logic [31:0] x);
    logic [63:0] prod;
    prod = {32'd0, x} * {32'd0, DIV100_MAGIC};
    return {5'd0, prod[63:37]};
  endfunction

  // Signed divide by 100, truncating toward zero.
  function automatic logic signed [31:0] sdiv100(input logic signed [31:0] x);
    logic [31:0] mag;
    logic [31:0] q;
    mag = x[31] ? (~$unsigned(x) + 32'd1) : $unsigned(x);
    q = udiv100(mag);
    return x[31] ? $signed(~q + 32'd1) : $signed(q);
  endfunction

endpackage

// File: rtl/core/esc_div.sv
module esc_div
  import esc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [DIV_W-1:0] num,
  input  logic [DIV_W-1:0] den,
  input  side_t            side_in,
  output logic             out_valid,
  output logic [DIV_W-1:0] quo,
  output side_t            side_out
);

  // One quotient bit per stage, restoring division.
  logic [DIV_W-1:0] rem [0:DIV_W-1];
  logic [DIV_W-1:0] nm  [0:DIV_W-1];
  logic [DIV_W-1:0] qt  [0:DIV_W-1];
  logic [DIV_W-1:0] dn  [0:DIV_W-1];
  side_t            sd  [0:DIV_W-1];
  logic             vl  [0:DIV_W-1];

  for (genvar k = 0; k < DIV_W; k++) begin : g_stage
    logic [DIV_W-1:0] r_in;
    logic [DIV_W-1:0] n_in;
    logic [DIV_W-1:0] q_in;
    logic [DIV_W-1:0] d_in;
    side_t            s_in;
    logic             v_in;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign r_in = '0;
      assign n_in = num;
      assign q_in = '0;
      assign d_in = den;
      assign s_in = side_in;
      assign v_in = in_valid;
    end else begin : g_rest
      assign r_in = rem[k-1];
      assign n_in = nm[k-1];
      assign q_in = qt[k-1];
      assign d_in = dn[k-1];
      assign s_in = sd[k-1];
      assign v_in = vl[k-1];
    end

    assign trial = {r_in, n_in[DIV_W-1]};
    assign diff  = trial - {1'b0, d_in};
    assign ge    = (trial >= {1'b0, d_in});

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[k] <= 1'b0;
      end else if (en) begin
        vl[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        nm[k]  <= {n_in[DIV_W-2:0], 1'b0};
        qt[k]  <= {q_in[DIV_W-2:0], ge};
        dn[k]  <= d_in;
        sd[k]  <= s_in;
      end
    end
  end

  assign out_valid = vl[DIV_W-1];
  assign quo       = qt[DIV_W-1];
  assign side_out  = sd[DIV_W-1];

endmodule

// File: rtl/core/esc_datapath.sv
module esc_datapath
  import esc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  calib_t      calib,
  input  logic        in_valid,
  input  logic [19:0] raw_temp,
  input  logic [19:0] raw_pressure,
  input  logic [15:0] raw_humidity,
  output logic        out_valid,
  output result_t     result
);

  // Calibration fields; the user must change the registers only while the block is idle; the block does not enforce it.
  logic signed [31:0] t1, t2, t3;
  logic signed [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, p10;
  logic signed [31:0] h1, h2, h3, h4, h5, h6, h7;

  assign t1  = $signed({16'd0, calib.temp[15:0]});
  assign t2  = sx16(calib.temp[31:16]);
  assign t3  = sx8(calib.temp[39:32]);
  assign p1  = $signed({16'd0, calib.pres_a[15:0]});
  assign p2  = sx16(calib.pres_a[31:16]);
  assign p3  = sx8(calib.pres_a[39:32]);
  assign p4  = sx16(calib.pres_a[55:40]);
  assign p6  = sx8(calib.pres_a[63:56]);
  assign p5  = sx16(calib.pres_b[15:0]);
  assign p7  = sx8(calib.pres_b[23:16]);
  assign p8  = sx16(calib.pres_b[39:24]);
  assign p9  = sx16(calib.pres_b[55:40]);
  assign p10 = $signed({24'd0, calib.pres_b[63:56]});
  assign h1  = $signed({20'd0, calib.hum[11:0]});
  assign h2  = $signed({20'd0, calib.hum[23:12]});
  assign h3  = sx8(calib.hum[31:24]);
  assign h4  = sx8(calib.hum[39:32]);
  assign h5  = sx8(calib.hum[47:40]);
  assign h6  = $signed({24'd0, calib.hum[55:48]});
  assign h7  = sx8(calib.hum[63:56]);

  logic [11:1] vpre;
  logic [7:1]  vpost;

  // Stages 1 to 4: fine temperature.
  logic signed [31:0] ta1, tb0_2, tqq2, tb3, tc0_3, tf4;
  logic [19:0] rp1, rp2, rp3, rp4, rp5, rp6, rp7, rp8;
  logic [15:0] rh1, rh2, rh3, rh4, rh5, rh6, rh7;
  logic signed [31:0] tq_c;

  assign tq_c = ta1 >>> 1;

  always_ff @(posedge clk) begin
    if (en) begin
      ta1   <= $signed({15'd0, raw_temp[19:3]}) - (t1 <<< 1);
      rp1   <= raw_pressure;
      rh1   <= raw_humidity;
      tb0_2 <= ta1 * t2;
      tqq2  <= tq_c * tq_c;
      rp2   <= rp1;
      rh2   <= rh1;
      tb3   <= tb0_2 >>> 11;
      tc0_3 <= (tqq2 >>> 12) * (t3 <<< 4);
      rp3   <= rp2;
      rh3   <= rh2;
      tf4   <= tb3 + (tc0_3 >>> 14);
      rp4   <= rp3;
      rh4   <= rh3;
    end
  end

  // Stage 5: centidegrees and the pressure offset term.
  logic signed [31:0] cent5, pa5, t5_c;
  assign t5_c = (tf4 * 32'sd5) + TEMP_ROUND;

  always_ff @(posedge clk) begin
    if (en) begin
      cent5 <= t5_c >>> 8;
      pa5   <= (tf4 >>> 1) - PRES_OFFSET;
      rp5   <= rp4;
      rh5   <= rh4;
    end
  end

  // Stage 6: products on centidegrees and the pressure offset.
  logic signed [31:0] c6_c, pq6_c;
  logic               cneg6;
  logic [31:0]        cmag6;
  logic signed [31:0] cent6, psq6, pap5_6, pp2a6, hm3_6, hm4_6, hm5_6, hm7_6;

  assign c6_c  = cent5 + 32'sd50;
  assign pq6_c = pa5 >>> 2;

  always_ff @(posedge clk) begin
    if (en) begin
      cneg6  <= c6_c[31];
      cmag6  <= c6_c[31] ? $unsigned(32'sd99 - c6_c) : $unsigned(c6_c);
      cent6  <= cent5;
      psq6   <= pq6_c * pq6_c;
      pap5_6 <= pa5 * p5;
      pp2a6  <= p2 * pa5;
      hm3_6  <= cent5 * h3;
      hm4_6  <= cent5 * h4;
      hm5_6  <= cent5 * h5;
      hm7_6  <= cent5 * h7;
      rp6    <= rp5;
      rh6    <= rh5;
    end
  end

  // Stage 7: divisions by 100 and the first pressure terms.
  logic [31:0]        degq7;
  logic               cneg7;
  logic signed [31:0] pb7, pa2m7, pp2a7, d3_7, d4_7, d5_7, d7_7, cent7, pb6m_c;

  assign pb6m_c = (psq6 >>> 11) * p6;

  always_ff @(posedge clk) begin
    if (en) begin
      degq7 <= udiv100(cmag6);
      cneg7 <= cneg6;
      pb7   <= (pb6m_c >>> 2) + (pap5_6 <<< 1);
      pa2m7 <= (psq6 >>> 13) * (p3 <<< 5);
      pp2a7 <= pp2a6;
      d3_7  <= sdiv100(hm3_6);
      d4_7  <= sdiv100(hm4_6);
      d5_7  <= sdiv100(hm5_6);
      d7_7  <= sdiv100(hm7_6);
      cent7 <= cent6;
      rp7   <= rp6;
      rh7   <= rh6;
    end
  end

  // Stage 8: saturated degrees, pressure terms, first humidity terms.
  logic [7:0]         deg8, deg9, deg10;
  logic [7:0]         deg8_c;
  logic [31:0]        degn_c;
  logic signed [31:0] pa2s_c, pb2_8, pa2_8, x1_8, z8, x4_8, d4_8;

  assign degn_c = ~degq7 + 32'd1;
  assign pa2s_c = (pa2m7 >>> 3) + (pp2a7 >>> 1);

  always_comb begin
    if (cneg7) begin
      deg8_c = (degq7 > 32'd128) ? 8'h80 : degn_c[7:0];
    end else begin
      deg8_c = (degq7 > 32'd127) ? 8'h7F : degq7[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      deg8  <= deg8_c;
      pb2_8 <= (pb7 >>> 2) + (p4 <<< 16);
      pa2_8 <= pa2s_c >>> 18;
      x1_8  <= $signed({16'd0, rh7}) - (h1 <<< 4) - (d3_7 >>> 1);
      z8    <= cent7 * d5_7;
      x4_8  <= ((h6 <<< 7) + d7_7) >>> 4;
      d4_8  <= d4_7;
      rp8   <= rp7;
    end
  end

  // Stage 9: raw pressure correction and the divisor product.
  logic signed [31:0] bs9_c;
  logic [31:0]        pv9;
  logic signed [31:0] pa3m9, zd9, d4_9, x1_9, x4_9;

  assign bs9_c = pb2_8 >>> 12;

  always_ff @(posedge clk) begin
    if (en) begin
      deg9  <= deg8;
      pv9   <= PRES_BASE - {12'd0, rp8} - $unsigned(bs9_c);
      pa3m9 <= (PRES_ONE + pa2_8) * p1;
      zd9   <= sdiv100(z8 >>> 6);
      d4_9  <= d4_8;
      x1_9  <= x1_8;
      x4_9  <= x4_8;
    end
  end

  // Stage 10: scaled numerator, divisor, humidity inner term.
  logic signed [31:0] dvs10_c;
  logic [31:0]        pv3_10, dv10;
  logic signed [31:0] inner10, x1_10, x4_10;

  assign dvs10_c = pa3m9 >>> 15;

  always_ff @(posedge clk) begin
    if (en) begin
      deg10   <= deg9;
      pv3_10  <= pv9 * PRES_SCALE;
      dv10    <= $unsigned(dvs10_c);
      inner10 <= d4_9 + zd9 + HUM_ONE;
      x1_10   <= x1_9;
      x4_10   <= x4_9;
    end
  end

  // Stage 11: numerator alignment and the zero-divisor flag.
  logic        big11_c;
  logic [31:0] num11, dv11;
  side_t       side11;

  assign big11_c = pv3_10[31] | pv3_10[30];

  always_ff @(posedge clk) begin
    if (en) begin
      num11        <= big11_c ? pv3_10 : {pv3_10[30:0], 1'b0};
      dv11         <= dv10;
      side11.deg   <= deg10;
      side11.fault <= (dv10 == 32'd0);
      side11.big   <= big11_c;
      side11.x1    <= x1_10;
      side11.x2m   <= h2 * inner10;
      side11.x4    <= x4_10;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpre <= '0;
    end else if (en) begin
      vpre <= {vpre[10:1], in_valid};
    end
  end

  logic        dvalid;
  logic [31:0] quo;
  side_t       dside;

  esc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (vpre[11]),
    .num      (num11),
    .den      (dv11),
    .side_in  (side11),
    .out_valid(dvalid),
    .quo      (quo),
    .side_out (dside)
  );

  // Post-division stages: pressure polynomial and humidity in parallel.
  logic [31:0]        pv_1, pv_2, pv_3, pv_4;
  logic signed [31:0] x1_p1, x2_p1, x4_p1, x4_p2, x4_p3;
  logic [7:0]         dg1, dg2, dg3, dg4, dg5, dg6;
  logic               ft1, ft2, ft3, ft4, ft5, ft6;
  logic [31:0]        sh2;
  logic signed [31:0] s2m2, cb2_2, cb_2, x3_2, cb_c, x3r_c;
  logic signed [31:0] s1m3, s2_3, cb3_3, rr3, x3_3;
  logic signed [31:0] s1_4, s2_4, s3m4, x6m4, x3_4;
  logic signed [31:0] pa5p, chm5, sum5_c, ch6_c;
  logic [31:0]        hn6;
  logic [16:0]        chn6;
  logic [34:0]        hprod_c;
  logic [31:0]        hq_c;
  result_t            res7;

  assign cb_c    = $signed({8'd0, pv_1[31:8]});
  assign x3r_c   = x3_2 >>> 14;
  assign sum5_c  = s1_4 + s2_4 + (s3m4 >>> 17) + (p7 <<< 7);
  assign ch6_c   = chm5 >>> 12;
  assign hprod_c = {18'd0, chn6} * {17'd0, DIV1000_MAGIC};
  assign hq_c    = udiv100(hn6);

  always_ff @(posedge clk) begin
    if (en) begin
      pv_1  <= dside.big ? {quo[30:0], 1'b0} : quo;
      x1_p1 <= dside.x1;
      x2_p1 <= dside.x2m >>> 10;
      x4_p1 <= dside.x4;
      dg1   <= dside.deg;
      ft1   <= dside.fault;

      sh2   <= {3'd0, pv_1[31:3]} * {3'd0, pv_1[31:3]};
      s2m2  <= $signed({2'd0, pv_1[31:2]}) * p8;
      cb_2  <= cb_c;
      cb2_2 <= cb_c * cb_c;
      x3_2  <= x1_p1 * x2_p1;
      x4_p2 <= x4_p1;
      pv_2  <= pv_1;
      dg2   <= dg1;
      ft2   <= ft1;

      s1m3  <= p9 * $signed({13'd0, sh2[31:13]});
      s2_3  <= s2m2 >>> 13;
      cb3_3 <= cb2_2 * cb_2;
      rr3   <= x3r_c * x3r_c;
      x3_3  <= x3_2;
      x4_p3 <= x4_p2;
      pv_3  <= pv_2;
      dg3   <= dg2;
      ft3   <= ft2;

      s1_4  <= s1m3 >>> 12;
      s2_4  <= s2_3;
      s3m4  <= cb3_3 * p10;
      x6m4  <= x4_p3 * (rr3 >>> 10);
      x3_4  <= x3_3;
      pv_4  <= pv_3;
      dg4   <= dg3;
      ft4   <= ft3;

      pa5p  <= $signed(pv_4) + (sum5_c >>> 4);
      chm5  <= ((x3_4 + (x6m4 >>> 1)) >>> 10) * HUM_SCALE;
      dg5   <= dg4;
      ft5   <= ft4;

      hn6   <= pa5p[31] ? 32'd0 : ($unsigned(pa5p) + 32'd50);
      if (ch6_c[31]) begin
        chn6 <= 17'd500;
      end else if (ch6_c > HUM_MAX) begin
        chn6 <= 17'd100500;
      end else begin
        chn6 <= ch6_c[16:0] + 17'd500;
      end
      dg6   <= dg5;
      ft6   <= ft5;

      res7.temperature_c  <= dg6;
      res7.pressure_fault <= ft6;
      res7.humidity_pct   <= hprod_c[33:27];
      if (ft6) begin
        res7.pressure_hpa <= 11'd0;
      end else if (hq_c > 32'd2047) begin
        res7.pressure_hpa <= 11'd2047;
      end else begin
        res7.pressure_hpa <= hq_c[10:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpost <= '0;
    end else if (en) begin
      vpost <= {vpost[6:1], dvalid};
    end
  end

  assign out_valid = vpost[7];
  assign result    = res7;

endmodule

// File: rtl/core/env_sensor_compensation.sv
// Environmental sensor compensation.
//
// The input stream carries one set of raw temperature, pressure and humidity
// readings per request on s_tvalid/s_tready/s_tdata. The output stream returns
// one request per input: rounded whole degrees Celsius, hectopascal and percent
// relative humidity in m_tdata, and in m_tuser a flag that marks a zero pressure
// divisor (the pressure field is then zero).
//
// The calibration words are loaded through cfg_we/cfg_index/cfg_data, one
// register per write, and should be written only while no request is in flight.
//
// The datapath is a 50-stage pipeline: 11 stages of temperature and pressure
// setup, a 32-stage divider that resolves one quotient bit per stage, and 7
// stages of pressure polynomial and humidity finishing. A request passes these
// stages and then the output register to m_tvalid. One request is accepted every
// cycle while s_tready is high; the divider depth sets the latency, not the rate.
//
// Reset clears the calibration registers, the pipeline valid bits and the output
// register. When the receiver stalls, the pipeline keeps moving until the output
// register and one skid entry are full; s_tready then drops and every stage holds.
module env_sensor_compensation
  import esc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [55:0]      s_tdata,   // raw_temp[19:0], raw_pressure[39:20], raw_humidity[55:40]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [31:0]      m_tdata,   // temperature_c[7:0], pressure_hpa[18:8],
                                      // humidity_pct[25:19], zero padding[31:26]
  output logic             m_tuser,   // pressure_fault
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  calib_t calib;

  // Calibration registers, written by index.
  always_ff @(posedge clk) begin
    if (rst) begin
      calib <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_TEMP_CALIB:   calib.temp   <= cfg_data[TCAL_W-1:0];
        REG_PRES_CALIB_A: calib.pres_a <= cfg_data;
        REG_PRES_CALIB_B: calib.pres_b <= cfg_data;
        REG_HUM_CALIB:    calib.hum    <= cfg_data;
      endcase
    end
  end

  // The pipeline advances whenever the skid entry is free.
  logic    en;
  logic    pipe_valid;
  result_t pipe_res;
  logic    out_valid;
  result_t out_res;
  logic    skid_valid;
  result_t skid_res;
  logic    take;

  assign en   = ~skid_valid;
  assign take = m_tready | ~out_valid;

  esc_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .calib       (calib),
    .in_valid    (s_tvalid & en),
    .raw_temp    (s_tdata[19:0]),
    .raw_pressure(s_tdata[39:20]),
    .raw_humidity(s_tdata[55:40]),
    .out_valid   (pipe_valid),
    .result      (pipe_res)
  );

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= pipe_valid;
      end
    end else if (pipe_valid && en) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_res <= skid_valid ? skid_res : pipe_res;
    end else if (pipe_valid && en) begin
      skid_res <= pipe_res;
    end
  end

  assign s_tready = en;
  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_res.humidity_pct, out_res.pressure_hpa, out_res.temperature_c};
  assign m_tuser  = out_res.pressure_fault;

endmodule

// File: rtl/core/esc_checker.sv
module esc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser
);

  // Humidity is clamped to a valid percentage.
  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[25:19] <= 7'd100))
    else $error("humidity out of range");

  // A zero divisor reports zero pressure.
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[18:8] == 11'd0))
    else $error("pressure not zero on fault");

  // Reset empties the output side and leaves the input open.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!m_tvalid && s_tready))
    else $error("output valid after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind env_sensor_compensation esc_checker u_esc_checker (.*);
